@@ design/crh_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, register indexes and reset values for the color/redshift histogram.
// Used by crh_lane, crh_zbin and color_redshift_histogram_top; depends on nothing.
package crh_pkg;

  localparam int MAX_COLOR_BINS_DEF    = 64;
  localparam int MAX_REDSHIFT_BINS_DEF = 64;
  localparam int NUM_COLORS_DEF        = 5;
  localparam int COUNT_WIDTH_DEF       = 32;

  localparam int NUM_BANDS = 6;

  typedef enum logic [2:0] {
    REG_COLOR_LOWER        = 3'd0,
    REG_COLOR_SCALE        = 3'd1,
    REG_REDSHIFT_LOWER     = 3'd2,
    REG_REDSHIFT_SCALE     = 3'd3,
    REG_COLOR_BINS_USED    = 3'd4,
    REG_REDSHIFT_BINS_USED = 3'd5,
    REG_Y_BAND_ENABLE      = 3'd6
  } reg_index_t;

  localparam logic signed [15:0] COLOR_LOWER_RST    = -16'sd512;
  localparam logic [15:0]        COLOR_SCALE_RST    = 16'd2509;
  localparam logic [15:0]        REDSHIFT_LOWER_RST = 16'd0;
  localparam logic [15:0]        REDSHIFT_SCALE_RST = 16'd3136;
  localparam logic [6:0]         COLOR_BINS_RST     = 7'd50;
  localparam logic [6:0]         REDSHIFT_BINS_RST  = 7'd50;
  localparam logic               Y_BAND_RST         = 1'b1;

  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_READ       = 1'b1;

  typedef struct packed {
    logic signed [15:0] color_lower;
    logic [15:0]        color_scale;
    logic [15:0]        redshift_lower;
    logic [15:0]        redshift_scale;
    logic [6:0]         color_bins_used;
    logic [6:0]         redshift_bins_used;
    logic               y_band_enable;
  } cfg_t;

  typedef struct packed {
    logic ofs_en;
    logic mul_en;
    logic addr_en;
    logic rd_en;
    logic wr_en;
    logic accumulate;
    logic clr_en;
  } ctrl_t;

endpackage

@@ design/crh_zbin.sv @@
`timescale 1ns / 1ps
// Redshift binning unit: offset, reciprocal-width multiply and range check.
// Depends on crh_pkg for the configuration and control structs.
module crh_zbin #(
  parameter int MAX_REDSHIFT_BINS = crh_pkg::MAX_REDSHIFT_BINS_DEF,
  localparam int ZB_W = $clog2(MAX_REDSHIFT_BINS)
) (
  input  logic               clk,
  input  logic [15:0]        redshift,
  input  crh_pkg::cfg_t      cfg,
  input  crh_pkg::ctrl_t     ctrl,
  output logic               zok,
  output logic [ZB_W-1:0]    zbin
);

  logic signed [16:0] ofs;
  logic               neg;
  logic [31:0]        prod;
  logic [11:0]        bin;

  always_ff @(posedge clk) begin
    if (ctrl.ofs_en) begin
      ofs <= $signed({1'b0, redshift}) - $signed({1'b0, cfg.redshift_lower});
    end
    if (ctrl.mul_en) begin
      neg  <= ofs[16];
      prod <= ofs[15:0] * cfg.redshift_scale;
    end
  end

  assign bin  = prod[31:20];
  assign zok  = !neg && (bin < 12'(cfg.redshift_bins_used)) &&
                (bin < 12'(MAX_REDSHIFT_BINS));
  assign zbin = bin[ZB_W-1:0];

endmodule

@@ design/crh_lane.sv @@
`timescale 1ns / 1ps
// One color lane: color offset, bin multiply, and the counter memory of that color
// with its read-modify-write and clearing port. Depends on crh_pkg.
module crh_lane #(
  parameter int MAX_COLOR_BINS    = crh_pkg::MAX_COLOR_BINS_DEF,
  parameter int MAX_REDSHIFT_BINS = crh_pkg::MAX_REDSHIFT_BINS_DEF,
  parameter int COUNT_WIDTH       = crh_pkg::COUNT_WIDTH_DEF,
  localparam int CB_W = $clog2(MAX_COLOR_BINS),
  localparam int ZB_W = $clog2(MAX_REDSHIFT_BINS),
  localparam int AW   = CB_W + ZB_W
) (
  input  logic                    clk,
  input  logic signed [15:0]      mag_hi,
  input  logic signed [15:0]      mag_lo,
  input  logic                    lane_en,
  input  crh_pkg::cfg_t           cfg,
  input  crh_pkg::ctrl_t          ctrl,
  input  logic                    zok,
  input  logic [ZB_W-1:0]         zbin,
  input  logic [CB_W-1:0]         rd_cb,
  input  logic [ZB_W-1:0]         rd_zb,
  input  logic [AW-1:0]           clr_addr,
  output logic                    hit,
  output logic [COUNT_WIDTH-1:0]  rd_data
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] mem [2**AW];

  logic signed [18:0]     ofs;
  logic                   neg;
  logic [33:0]            prod;
  logic [17:0]            bin;
  logic                   hit_next;
  logic [AW-1:0]          addr;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_next;

  assign bin      = prod[33:16];
  assign hit_next = ctrl.accumulate && lane_en && zok && !neg &&
                    (bin < 18'(cfg.color_bins_used)) && (bin < 18'(MAX_COLOR_BINS));
  assign cnt_next = (cnt == CNT_MAX) ? cnt : cnt + COUNT_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (ctrl.ofs_en) begin
      ofs <= 19'(mag_hi) - 19'(mag_lo) - 19'(cfg.color_lower);
    end
    if (ctrl.mul_en) begin
      neg  <= ofs[18];
      prod <= ofs[17:0] * cfg.color_scale;
    end
    if (ctrl.addr_en) begin
      hit  <= hit_next;
      addr <= ctrl.accumulate ? {bin[CB_W-1:0], zbin} : {rd_cb, rd_zb};
    end
    if (ctrl.rd_en) begin
      cnt <= mem[addr];
    end
    if (ctrl.clr_en) begin
      mem[clr_addr] <= '0;
    end else if (ctrl.wr_en && hit) begin
      mem[addr] <= cnt_next;
    end
  end

  assign rd_data = cnt;

endmodule

@@ design/color_redshift_histogram_top.sv @@
`timescale 1ns / 1ps
// Top level of the color versus redshift histogram: configuration registers,
// item sequencer, color lanes, redshift unit and result merge. Depends on crh_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one item per transfer: an
//   accumulate (operation 0) with six magnitudes and a redshift, or a read
//   (operation 1) of one counter. Each item yields exactly one result on the
//   output channel (out_valid/out_ready): bin_count for a read, counted_mask
//   for an accumulate.
//   The configuration channel (cfg_valid/cfg_ready) is always ready; writes to
//   an index beyond the register list are dropped.
//   An item steps through the offset, multiply, address, read, write and done
//   states, and out_valid is set from the done state once the output is free;
//   one item is in flight at a time, set by each lane's counter read-modify-write.
//   Reset loads the register defaults and starts a clearing pass over the
//   counter memories, one address per cycle in all lanes at once, until the
//   last address has been cleared; during it in_ready stays low. A stalled
//   receiver holds the finished result in the output register; one further
//   item may be taken and waits fully computed.
module color_redshift_histogram_top #(
  parameter int MAX_COLOR_BINS    = crh_pkg::MAX_COLOR_BINS_DEF,
  parameter int MAX_REDSHIFT_BINS = crh_pkg::MAX_REDSHIFT_BINS_DEF,
  parameter int NUM_COLORS        = crh_pkg::NUM_COLORS_DEF,
  parameter int COUNT_WIDTH       = crh_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic signed [15:0] mag_u,
  input  logic signed [15:0] mag_g,
  input  logic signed [15:0] mag_r,
  input  logic signed [15:0] mag_i,
  input  logic signed [15:0] mag_z,
  input  logic signed [15:0] mag_y,
  input  logic [15:0]        redshift,
  input  logic [2:0]         read_color_index,
  input  logic [5:0]         read_color_bin,
  input  logic [5:0]         read_redshift_bin,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        bin_count,
  output logic [4:0]         counted_mask
);

  localparam int CB_W = $clog2(MAX_COLOR_BINS);
  localparam int ZB_W = $clog2(MAX_REDSHIFT_BINS);
  localparam int AW   = CB_W + ZB_W;
  localparam logic [AW-1:0] CLR_LAST = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_OFF, S_MUL, S_ADDR, S_READ, S_WRITE, S_DONE
  } state_t;

  state_t             state;
  crh_pkg::cfg_t      cfg;
  crh_pkg::ctrl_t     ctrl;
  logic               clearing;
  logic [AW-1:0]      clr_addr;

  logic               op;
  logic signed [15:0] mags [crh_pkg::NUM_BANDS];
  logic [15:0]        zval;
  logic [2:0]         rd_ci;
  logic [5:0]         rd_cb;
  logic [5:0]         rd_zb;

  logic [31:0]        res_count;
  logic [4:0]         res_mask;
  logic [31:0]        count_next;
  logic [4:0]         mask_next;

  logic                   zok;
  logic [ZB_W-1:0]        zbin;
  logic [NUM_COLORS-1:0]  hits;
  logic [COUNT_WIDTH-1:0] lane_data [NUM_COLORS];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && !clearing;

  always_comb begin
    ctrl            = '0;
    ctrl.ofs_en     = (state == S_OFF);
    ctrl.mul_en     = (state == S_MUL);
    ctrl.addr_en    = (state == S_ADDR);
    ctrl.rd_en      = (state == S_READ);
    ctrl.wr_en      = (state == S_WRITE);
    ctrl.accumulate = (op == crh_pkg::OP_ACCUMULATE);
    ctrl.clr_en     = clearing;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_lower        <= crh_pkg::COLOR_LOWER_RST;
      cfg.color_scale        <= crh_pkg::COLOR_SCALE_RST;
      cfg.redshift_lower     <= crh_pkg::REDSHIFT_LOWER_RST;
      cfg.redshift_scale     <= crh_pkg::REDSHIFT_SCALE_RST;
      cfg.color_bins_used    <= crh_pkg::COLOR_BINS_RST;
      cfg.redshift_bins_used <= crh_pkg::REDSHIFT_BINS_RST;
      cfg.y_band_enable      <= crh_pkg::Y_BAND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crh_pkg::REG_COLOR_LOWER:        cfg.color_lower        <= cfg_data;
        crh_pkg::REG_COLOR_SCALE:        cfg.color_scale        <= cfg_data;
        crh_pkg::REG_REDSHIFT_LOWER:     cfg.redshift_lower     <= cfg_data;
        crh_pkg::REG_REDSHIFT_SCALE:     cfg.redshift_scale     <= cfg_data;
        crh_pkg::REG_COLOR_BINS_USED:    cfg.color_bins_used    <= cfg_data[6:0];
        crh_pkg::REG_REDSHIFT_BINS_USED: cfg.redshift_bins_used <= cfg_data[6:0];
        crh_pkg::REG_Y_BAND_ENABLE:      cfg.y_band_enable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == CLR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    mask_next  = '0;
    count_next = '0;
    for (int k = 0; k < NUM_COLORS; k++) begin
      mask_next[k] = hits[k];
    end
    if (op == crh_pkg::OP_READ && 32'(rd_cb) < MAX_COLOR_BINS &&
        32'(rd_zb) < MAX_REDSHIFT_BINS) begin
      for (int k = 0; k < NUM_COLORS; k++) begin
        if (rd_ci == 3'(k)) begin
          count_next = 32'(lane_data[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op      <= operation;
            mags[0] <= mag_u;
            mags[1] <= mag_g;
            mags[2] <= mag_r;
            mags[3] <= mag_i;
            mags[4] <= mag_z;
            mags[5] <= mag_y;
            zval    <= redshift;
            rd_ci   <= read_color_index;
            rd_cb   <= read_color_bin;
            rd_zb   <= read_redshift_bin;
            state   <= S_OFF;
          end
        end
        S_OFF:  state <= S_MUL;
        S_MUL:  state <= S_ADDR;
        S_ADDR: state <= S_READ;
        S_READ: state <= S_WRITE;
        S_WRITE: begin
          res_count <= count_next;
          res_mask  <= mask_next;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            bin_count    <= res_count;
            counted_mask <= res_mask;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  crh_zbin #(
    .MAX_REDSHIFT_BINS(MAX_REDSHIFT_BINS)
  ) u_zbin (
    .clk      (clk),
    .redshift (zval),
    .cfg      (cfg),
    .ctrl     (ctrl),
    .zok      (zok),
    .zbin     (zbin)
  );

  for (genvar k = 0; k < NUM_COLORS; k++) begin : g_lane
    crh_lane #(
      .MAX_COLOR_BINS   (MAX_COLOR_BINS),
      .MAX_REDSHIFT_BINS(MAX_REDSHIFT_BINS),
      .COUNT_WIDTH      (COUNT_WIDTH)
    ) u_lane (
      .clk      (clk),
      .mag_hi   (mags[k]),
      .mag_lo   (mags[k+1]),
      .lane_en  ((k < 4) ? 1'b1 : cfg.y_band_enable),
      .cfg      (cfg),
      .ctrl     (ctrl),
      .zok      (zok),
      .zbin     (zbin),
      .rd_cb    (CB_W'(rd_cb)),
      .rd_zb    (ZB_W'(rd_zb)),
      .clr_addr (clr_addr),
      .hit      (hits[k]),
      .rd_data  (lane_data[k])
    );
  end

endmodule
